>>> rtl/mexp_pkg.sv
package mexp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SEED,
    ST_MUL,
    ST_UPDATE,
    ST_FINISH
  } mexp_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture a new item
    logic step;     // one interleaved multiply/reduce step on both lanes
    logic reduce;   // step reduces the base (square lane multiplies by one)
    logic update;   // commit lane results, reload the multiplier shifter
    logic advance;  // update also consumes one exponent bit
    logic finish;   // register the result
  } mexp_cmd_t;

endpackage

>>> rtl/modular_exponentiation_core.sv
// Channel  | Direction | Handshake               | Payload
// input    | in        | start, busy             | base_value_i, exponent_value_i
// result   | out       | result_valid_o (strobe) | power_residue_o
// config   | in        | cfg_valid_i, cfg_ready_o| cfg_data_i (modulus)
//
// An item first has its base reduced, then makes one multiply pass per
// exponent bit, each closed by an update, on the bit-serial modular
// multiplier: one multiplier bit per cycle, two lanes.
// busy is high from the accepting edge until the result is strobed; the next
// item may start in the strobe cycle. Reset loads the modulus with 23.
// Results are strobed for one cycle and cannot be held off.
module modular_exponentiation_core #(
  parameter int WORD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_BITS-1:0] base_value_i,
  input  logic [WORD_BITS-1:0] exponent_value_i,
  output logic                 result_valid_o,
  output logic [WORD_BITS-1:0] power_residue_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [WORD_BITS-1:0] cfg_data_i
);
  import mexp_pkg::*;

  localparam logic [WORD_BITS-1:0] ModulusReset = WORD_BITS'(23);

  logic [WORD_BITS-1:0] modulus_q;
  mexp_cmd_t            cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      modulus_q <= cfg_data_i;
    end
  end

  mexp_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_o         (cmd),
    .result_valid_o(result_valid_o)
  );

  mexp_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .modulus_i       (modulus_q),
    .base_value_i    (base_value_i),
    .exponent_value_i(exponent_value_i),
    .power_residue_o (power_residue_o)
  );

endmodule

>>> rtl/mexp_ctrl.sv
module mexp_ctrl #(
  parameter int WORD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output mexp_pkg::mexp_cmd_t cmd_o,
  output logic              result_valid_o
);
  import mexp_pkg::*;

  localparam int CntW = $clog2(WORD_BITS);
  localparam logic [CntW-1:0] LastCnt = CntW'(WORD_BITS - 1);

  mexp_state_e state_q, state_d;
  logic [CntW-1:0] step_q, step_d;
  logic [CntW-1:0] ebit_q, ebit_d;
  logic strobe_q, strobe_d;

  // next state and counters
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ebit_d  = ebit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_REDUCE;
          step_d  = LastCnt;
          ebit_d  = '0;
        end
      end
      ST_REDUCE: begin
        if (step_q == '0) begin
          state_d = ST_SEED;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_SEED: begin
        state_d = ST_MUL;
        step_d  = LastCnt;
      end
      ST_MUL: begin
        if (step_q == '0) begin
          state_d = ST_UPDATE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_UPDATE: begin
        step_d = LastCnt;
        if (ebit_q == LastCnt) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_MUL;
          ebit_d  = ebit_q + 1'b1;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o    = '0;
    strobe_d = 1'b0;
    unique case (state_q)
      ST_IDLE:   cmd_o.load = start;
      ST_REDUCE: begin
        cmd_o.step   = 1'b1;
        cmd_o.reduce = 1'b1;
      end
      ST_SEED:   cmd_o.update = 1'b1;
      ST_MUL:    cmd_o.step = 1'b1;
      ST_UPDATE: begin
        cmd_o.update  = 1'b1;
        cmd_o.advance = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        strobe_d     = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      ebit_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      ebit_q   <= ebit_d;
      strobe_q <= strobe_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = strobe_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |=> !strobe_q)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_finish_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (strobe_q && !busy))
    else $error("finish not followed by result strobe");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.update, cmd_o.finish}))
    else $error("conflicting datapath commands");

endmodule

>>> rtl/mexp_datapath.sv
module mexp_datapath #(
  parameter int WORD_BITS = 16
) (
  input  logic                 clk_i,
  input  mexp_pkg::mexp_cmd_t  cmd_i,
  input  logic [WORD_BITS-1:0] modulus_i,
  input  logic [WORD_BITS-1:0] base_value_i,
  input  logic [WORD_BITS-1:0] exponent_value_i,
  output logic [WORD_BITS-1:0] power_residue_o
);
  import mexp_pkg::*;

  localparam logic [WORD_BITS-1:0] One = WORD_BITS'(1);

  logic [WORD_BITS-1:0] shift_q, shift_d;
  logic [WORD_BITS-1:0] exp_q, exp_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [WORD_BITS-1:0] sq_q, sq_d;
  logic [WORD_BITS-1:0] mul_q, mul_d;   // acc * sq lane
  logic [WORD_BITS-1:0] sqr_q, sqr_d;   // sq * sq lane, also base reduction
  logic [WORD_BITS-1:0] res_q, res_d;
  logic [WORD_BITS-1:0] sqr_addend;
  logic                 mbit;

  // r' = (2r + bit * a) mod m, for r < m and a < m
  function automatic logic [WORD_BITS-1:0] horner_step(
    input logic [WORD_BITS-1:0] r,
    input logic [WORD_BITS-1:0] a,
    input logic                 b,
    input logic [WORD_BITS-1:0] m
  );
    logic [WORD_BITS:0] dbl;
    logic [WORD_BITS:0] sum;
    dbl = {r, 1'b0};
    if (dbl >= {1'b0, m}) begin
      dbl = dbl - {1'b0, m};
    end
    sum = dbl + (b ? {1'b0, a} : '0);
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return sum[WORD_BITS-1:0];
  endfunction

  assign mbit       = shift_q[WORD_BITS-1];
  assign sqr_addend = cmd_i.reduce ? One : sq_q;

  always_comb begin
    shift_d = shift_q;
    exp_d   = exp_q;
    acc_d   = acc_q;
    sq_d    = sq_q;
    mul_d   = mul_q;
    sqr_d   = sqr_q;
    res_d   = res_q;
    if (cmd_i.load) begin
      shift_d = base_value_i;
      exp_d   = exponent_value_i;
      acc_d   = One;
      mul_d   = '0;
      sqr_d   = '0;
    end
    if (cmd_i.step) begin
      // walk the multiplier bits from the top
      shift_d = {shift_q[WORD_BITS-2:0], 1'b0};
      mul_d   = horner_step(mul_q, acc_q, mbit, modulus_i);
      sqr_d   = horner_step(sqr_q, sqr_addend, mbit, modulus_i);
    end
    if (cmd_i.update) begin
      sq_d    = sqr_q;
      shift_d = sqr_q;
      mul_d   = '0;
      sqr_d   = '0;
      if (cmd_i.advance) begin
        exp_d = exp_q >> 1;
        if (exp_q[0]) begin
          acc_d = mul_q;
        end
      end
    end
    if (cmd_i.finish) begin
      // modulus below two leaves every residue at zero
      res_d = (modulus_i < WORD_BITS'(2)) ? '0 : acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    exp_q   <= exp_d;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    mul_q   <= mul_d;
    sqr_q   <= sqr_d;
    res_q   <= res_d;
  end

  assign power_residue_o = res_q;

endmodule
